[rtl/nsfc_pkg.sv]
// Package for the NMEA sentence framer and checker.
// Holds shared constants, character codes, result codes and the control state type.
// No dependencies.
package nsfc_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int HEADER_LEN       = 6;
    localparam int BYTE_W           = 8;
    localparam int IDX_W            = 6;
    localparam int CFG_IDX_W        = 2;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

    localparam logic [BYTE_W-1:0] GGA_SUM_RST = 8'd86;
    localparam logic [BYTE_W-1:0] RMC_SUM_RST = 8'd75;

    localparam logic [CFG_IDX_W-1:0] CFG_GGA_SUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RMC_SUM = 2'd1;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_CHECKSUM = 2'd1,
        ERR_BAD_HEX  = 2'd2,
        ERR_LENGTH   = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        TYPE_UNKNOWN = 2'd0,
        TYPE_GGA     = 2'd1,
        TYPE_RMC     = 2'd2
    } t_stype;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_ERR  = 2'd1,
        ST_RD   = 2'd2,
        ST_OUT  = 2'd3
    } t_state;

endpackage

[rtl/nsfc_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module nsfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/nmea_sentence_framer_checker.sv]
// Top level of the NMEA sentence framer and checksum checker.
// Depends on nsfc_pkg and nsfc_ram (sentence store).
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------------------
//   input   | in        | i_in_valid / o_in_stall | i_rx_byte
//   result  | out       | o_out_valid/i_out_stall | o_out_byte, o_byte_index, ...
//   config  | in        | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// Received bytes are taken while the block is idle. An error result is shown in the cycle
// after the CR; a replay instead steps through a sentence store read (ST_RD) and an output
// state (ST_OUT) for each byte, and holds in ST_OUT through any output stall.
// Input is stalled from the CR until the final result transaction is taken.
// Reset is synchronous, active low; it clears the framing state and restores the
// header registers. The sentence store has no reset; only written entries are read.
module nmea_sentence_framer_checker #(
    parameter int BUFFER_DEPTH = nsfc_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input byte channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [nsfc_pkg::BYTE_W-1:0]         i_rx_byte,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [nsfc_pkg::BYTE_W-1:0]         o_out_byte,
    output logic [nsfc_pkg::IDX_W-1:0]          o_byte_index,
    output logic                                o_sentence_valid,
    output logic [1:0]                          o_sentence_type,
    output logic [1:0]                          o_error_kind,
    output logic                                o_last,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [nsfc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [nsfc_pkg::BYTE_W-1:0]         i_cfg_data
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);

    // Decode one ASCII hex digit: {ok, value}.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b1, 4'(c - 8'h41 + 8'd10)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b1, 4'(c - 8'h61 + 8'd10)};
        end
        return v;
    endfunction

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    nsfc_pkg::t_state r_state, n_state;

    logic [7:0]        r_gga_sum, r_rmc_sum;
    logic              r_collecting, n_collecting;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [7:0]        r_run_xor, n_run_xor;
    logic              r_star, n_star;
    logic [7:0]        r_hdr_xor, n_hdr_xor;
    logic              r_ovf, n_ovf;
    logic [7:0]        r_prev1, r_prev2;      // last two stored bytes
    logic [FILL_W-1:0] r_len;                 // sentence length being replayed
    logic [ADDR_W-1:0] r_idx, n_idx;          // replay position
    logic [1:0]        r_type;
    logic [1:0]        r_err;

    // ---------------------------------------------------------------
    // Input side decode
    // ---------------------------------------------------------------
    logic       in_acc;
    logic       out_acc;
    logic       is_cr_end;      // CR that closes a sentence
    logic       do_store;       // byte goes into the sentence store path
    logic       has_room;
    logic [4:0] hx_hi, hx_lo;
    logic [1:0] chk_err;
    logic [1:0] chk_type;
    logic       rep_last;
    logic [7:0] ram_rdata;
    logic       ram_we, ram_re;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_acc   = o_out_valid && !i_out_stall;
    assign is_cr_end = in_acc && r_collecting && (i_rx_byte == nsfc_pkg::CH_CR);
    assign do_store  = in_acc && !is_cr_end &&
                       (r_collecting || (i_rx_byte == nsfc_pkg::CH_DOLLAR));
    assign has_room  = (r_fill < FILL_W'(BUFFER_DEPTH));

    assign hx_hi = hex_val(r_prev2);
    assign hx_lo = hex_val(r_prev1);

    // Classify the closing CR: length problems first, then bad digits, then mismatch.
    always_comb begin
        priority if (r_ovf || (r_fill < FILL_W'(2))) begin
            chk_err = nsfc_pkg::ERR_LENGTH;
        end else if (!hx_hi[4] || !hx_lo[4]) begin
            chk_err = nsfc_pkg::ERR_BAD_HEX;
        end else if ({hx_hi[3:0], hx_lo[3:0]} != r_run_xor) begin
            chk_err = nsfc_pkg::ERR_CHECKSUM;
        end else begin
            chk_err = nsfc_pkg::ERR_NONE;
        end
    end

    // GGA wins when both header sums match.
    always_comb begin
        priority if (r_hdr_xor == r_gga_sum) begin
            chk_type = nsfc_pkg::TYPE_GGA;
        end else if (r_hdr_xor == r_rmc_sum) begin
            chk_type = nsfc_pkg::TYPE_RMC;
        end else begin
            chk_type = nsfc_pkg::TYPE_UNKNOWN;
        end
    end

    assign rep_last = (FILL_W'(r_idx) == (r_len - FILL_W'(1)));

    // ---------------------------------------------------------------
    // Framing state update
    // ---------------------------------------------------------------
    always_comb begin
        n_collecting = r_collecting;
        n_fill       = r_fill;
        n_run_xor    = r_run_xor;
        n_star       = r_star;
        n_hdr_xor    = r_hdr_xor;
        n_ovf        = r_ovf;
        ram_we       = 1'b0;
        if (is_cr_end) begin
            // drop the frame; the replay works from r_len
            n_collecting = 1'b0;
            n_fill       = '0;
            n_run_xor    = '0;
            n_star       = 1'b0;
            n_hdr_xor    = '0;
            n_ovf        = 1'b0;
        end else if (do_store) begin
            n_collecting = 1'b1;
            if (!has_room) begin
                n_ovf = 1'b1;
            end else begin
                ram_we = 1'b1;
                n_fill = r_fill + FILL_W'(1);
                if (!r_star) begin
                    if (i_rx_byte == nsfc_pkg::CH_STAR) begin
                        n_star = 1'b1;
                    end else if (i_rx_byte != nsfc_pkg::CH_DOLLAR) begin
                        n_run_xor = r_run_xor ^ i_rx_byte;
                        if (r_fill < FILL_W'(nsfc_pkg::HEADER_LEN)) begin
                            n_hdr_xor = r_hdr_xor ^ i_rx_byte;
                        end
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Control FSM: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            nsfc_pkg::ST_IDLE: begin
                if (is_cr_end) begin
                    n_idx = '0;
                    if (chk_err != nsfc_pkg::ERR_NONE) begin
                        n_state = nsfc_pkg::ST_ERR;
                    end else begin
                        n_state = nsfc_pkg::ST_RD;
                    end
                end
            end
            nsfc_pkg::ST_ERR: begin
                if (out_acc) begin
                    n_state = nsfc_pkg::ST_IDLE;
                end
            end
            nsfc_pkg::ST_RD: begin
                n_state = nsfc_pkg::ST_OUT;
            end
            nsfc_pkg::ST_OUT: begin
                if (out_acc) begin
                    if (rep_last) begin
                        n_state = nsfc_pkg::ST_IDLE;
                    end else begin
                        n_state = nsfc_pkg::ST_RD;
                        n_idx   = r_idx + ADDR_W'(1);
                    end
                end
            end
            default: begin
                n_state = nsfc_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control FSM: outputs
    // ---------------------------------------------------------------
    always_comb begin
        o_in_stall       = 1'b1;
        o_out_valid      = 1'b0;
        o_out_byte       = '0;
        o_byte_index     = '0;
        o_sentence_valid = 1'b0;
        o_sentence_type  = nsfc_pkg::TYPE_UNKNOWN;
        o_error_kind     = nsfc_pkg::ERR_NONE;
        o_last           = 1'b0;
        ram_re           = 1'b0;
        unique case (r_state)
            nsfc_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            nsfc_pkg::ST_ERR: begin
                o_out_valid  = 1'b1;
                o_error_kind = r_err;
                o_last       = 1'b1;
            end
            nsfc_pkg::ST_RD: begin
                ram_re = 1'b1;
            end
            nsfc_pkg::ST_OUT: begin
                // read data holds in the RAM output register until the next read
                o_out_valid      = 1'b1;
                o_out_byte       = ram_rdata;
                o_byte_index     = nsfc_pkg::IDX_W'(r_idx);
                o_sentence_valid = 1'b1;
                o_sentence_type  = r_type;
                o_last           = rep_last;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequential logic
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= nsfc_pkg::ST_IDLE;
            r_gga_sum    <= nsfc_pkg::GGA_SUM_RST;
            r_rmc_sum    <= nsfc_pkg::RMC_SUM_RST;
            r_collecting <= 1'b0;
            r_fill       <= '0;
            r_run_xor    <= '0;
            r_star       <= 1'b0;
            r_hdr_xor    <= '0;
            r_ovf        <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state      <= n_state;
            r_collecting <= n_collecting;
            r_fill       <= n_fill;
            r_run_xor    <= n_run_xor;
            r_star       <= n_star;
            r_hdr_xor    <= n_hdr_xor;
            r_ovf        <= n_ovf;
            r_idx        <= n_idx;
            if (i_cfg_we) begin
                if (i_cfg_idx == nsfc_pkg::CFG_GGA_SUM) begin
                    r_gga_sum <= i_cfg_data;
                end else if (i_cfg_idx == nsfc_pkg::CFG_RMC_SUM) begin
                    r_rmc_sum <= i_cfg_data;
                end
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_prev2 <= r_prev1;
            r_prev1 <= i_rx_byte;
        end
        if (is_cr_end) begin
            r_len  <= r_fill;
            r_type <= chk_type;
            r_err  <= chk_err;
        end
    end

    // Sentence store: written while collecting, read only during replay,
    // so the input stall keeps writes and reads apart.
    nsfc_ram #(
        .WIDTH (nsfc_pkg::BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

endmodule

[rtl/nsfc_checker.sv]
// Port-level assertions for the NMEA sentence framer and checker.
// Depends on nsfc_pkg; bound to nmea_sentence_framer_checker below.
module nsfc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [nsfc_pkg::BYTE_W-1:0]    o_out_byte,
    input logic [nsfc_pkg::IDX_W-1:0]     o_byte_index,
    input logic                           o_sentence_valid,
    input logic [1:0]                     o_error_kind,
    input logic                           o_last
);

    logic out_acc;
    assign out_acc = o_out_valid && !i_out_stall;

    // no input transaction is taken while a result is pending
    a_stall_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input not stalled while result pending");

    // an error result is a single, final, zeroed transaction
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_sentence_valid) |->
        (o_last && o_error_kind != nsfc_pkg::ERR_NONE && o_out_byte == '0))
        else $error("malformed error result");

    // a replayed byte carries no error code
    a_replay_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sentence_valid) |-> (o_error_kind == nsfc_pkg::ERR_NONE))
        else $error("replay result with error code");

    // after the final transaction, input opens again
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last) |=> (!o_out_valid && !o_in_stall))
        else $error("input not reopened after final result");

    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_out_byte) && $stable(o_byte_index)))
        else $error("stalled result changed");

endmodule

bind nmea_sentence_framer_checker nsfc_checker u_nsfc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_out_byte       (o_out_byte),
    .o_byte_index     (o_byte_index),
    .o_sentence_valid (o_sentence_valid),
    .o_error_kind     (o_error_kind),
    .o_last           (o_last)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for nmea_sentence_framer_checker: directed sentences, then random
// sentence traffic with random gaps and stalls. Depends on nsfc_pkg and the framer RTL.
module testbench;

    // Character codes the predictor and the sentence builder need beyond the package ones.
    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CH_UA    = "A";
    localparam logic [7:0] CH_UF    = "F";
    localparam logic [7:0] CH_LA    = "a";
    localparam logic [7:0] CH_LF    = "f";
    localparam logic [7:0] CH_COMMA = ",";
    localparam int         HEX_RADIX = 16;

    // Register indexes past the two header sums; writes there must be ignored.
    localparam logic [nsfc_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [nsfc_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_TICKS = 8;         // idle cycles after the last result of a phase
    localparam int HOLD_CYCLES  = 300;       // one long receiver hold-off
    localparam int PHASE_BYTES  = 20;        // minimum random bytes per register setting
    localparam int NUM_PHASES   = 6;

    // One result transaction as seen on the output channel.
    typedef struct packed {
        logic [7:0]                 ch;
        logic [nsfc_pkg::IDX_W-1:0] idx;
        logic                       ok;
        nsfc_pkg::t_stype           kind;
        nsfc_pkg::t_err             err;
        logic                       last;
    } t_res;

    // One row of the directed stimulus: a received byte or a register write.
    typedef struct packed {
        logic                           is_reg;
        logic [nsfc_pkg::CFG_IDX_W-1:0] idx;
        logic [7:0]                     ch;
        logic                           check;   // CR row whose outcome is typed into the table
        nsfc_pkg::t_err                 err;
        nsfc_pkg::t_stype               kind;
    } t_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [nsfc_pkg::BYTE_W-1:0]    i_rx_byte;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic [nsfc_pkg::BYTE_W-1:0]    o_out_byte;
    logic [nsfc_pkg::IDX_W-1:0]     o_byte_index;
    logic                           o_sentence_valid;
    logic [1:0]                     o_sentence_type;
    logic [1:0]                     o_error_kind;
    logic                           o_last;
    logic                           i_cfg_we;
    logic [nsfc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [nsfc_pkg::BYTE_W-1:0]    i_cfg_data;

    nmea_sentence_framer_checker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_byte       (o_out_byte),
        .o_byte_index     (o_byte_index),
        .o_sentence_valid (o_sentence_valid),
        .o_sentence_type  (o_sentence_type),
        .o_error_kind     (o_error_kind),
        .o_last           (o_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Framer state mirrored from the byte stream
    // ------------------------------------------------------------------
    logic [7:0] frame_buf [nsfc_pkg::BUFFER_DEPTH_DEF];
    int         frame_len  = 0;
    logic       in_frame   = 1'b0;
    logic [7:0] sum_xor    = '0;
    logic       past_star  = 1'b0;
    logic [7:0] head_xor   = '0;
    logic       too_long   = 1'b0;
    logic [7:0] gga_key    = nsfc_pkg::GGA_SUM_RST;
    logic [7:0] rmc_key    = nsfc_pkg::RMC_SUM_RST;

    t_res             sentence_out_q [$];   // results owed by the block, oldest first
    nsfc_pkg::t_err   last_err;             // outcome of the most recent CR
    nsfc_pkg::t_stype last_kind;

    t_row       dir_rows [$];
    logic [7:0] tx_burst [$];

    int   mismatches     = 0;
    int   results_seen   = 0;
    int   bytes_offered  = 0;
    int   replayed       = 0;
    int   err_tally [4]  = '{default: 0};
    int   hold_offs_done = 0;
    int   cycle_count    = 0;
    logic hold_off_pending = 1'b0;
    logic no_idle          = 1'b0;

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    function automatic void note_fault(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function automatic string res_text(input t_res r);
        return $sformatf("byte=%02h idx=%0d valid=%0b type=%0d err=%0d last=%0b",
                         r.ch, r.idx, r.ok, int'(r.kind), int'(r.err), r.last);
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        return -1;
    endfunction

    // Store one byte of an open sentence; fold it into the checksum and header sums
    // until the first star. A second dollar is stored but never summed.
    function automatic void keep_char(input logic [7:0] c);
        if (frame_len >= nsfc_pkg::BUFFER_DEPTH_DEF) begin
            too_long = 1'b1;
            return;
        end
        if (!past_star) begin
            if (c == nsfc_pkg::CH_STAR) begin
                past_star = 1'b1;
            end else if (c != nsfc_pkg::CH_DOLLAR) begin
                sum_xor ^= c;
                if (frame_len < nsfc_pkg::HEADER_LEN) head_xor ^= c;
            end
        end
        frame_buf[frame_len] = c;
        frame_len++;
    endfunction

    // Advance the mirrored framer by one accepted byte; at a CR, queue what the block owes.
    function automatic void frame_char(input logic [7:0] c);
        nsfc_pkg::t_err   err;
        nsfc_pkg::t_stype kind;
        int               hi;
        int               lo;
        t_res             r;
        if (!in_frame) begin
            // hunting: drop everything but a dollar
            if (c == nsfc_pkg::CH_DOLLAR) begin
                in_frame = 1'b1;
                keep_char(c);
            end
            return;
        end
        if (c != nsfc_pkg::CH_CR) begin
            keep_char(c);
            return;
        end
        err  = nsfc_pkg::ERR_NONE;
        kind = nsfc_pkg::TYPE_UNKNOWN;
        if (too_long || frame_len < 2) begin
            err = nsfc_pkg::ERR_LENGTH;
        end else begin
            hi = hex_value(frame_buf[frame_len-2]);
            lo = hex_value(frame_buf[frame_len-1]);
            if (hi < 0 || lo < 0) err = nsfc_pkg::ERR_BAD_HEX;
            else if (8'(hi * HEX_RADIX + lo) != sum_xor) err = nsfc_pkg::ERR_CHECKSUM;
        end
        if (err != nsfc_pkg::ERR_NONE) begin
            r      = '0;
            r.err  = err;
            r.last = 1'b1;
            sentence_out_q.push_back(r);
            err_tally[int'(err)]++;
        end else begin
            // GGA wins when both header sums match
            if (head_xor == gga_key) kind = nsfc_pkg::TYPE_GGA;
            else if (head_xor == rmc_key) kind = nsfc_pkg::TYPE_RMC;
            for (int k = 0; k < frame_len; k++) begin
                r.ch   = frame_buf[k];
                r.idx  = nsfc_pkg::IDX_W'(k);
                r.ok   = 1'b1;
                r.kind = kind;
                r.err  = nsfc_pkg::ERR_NONE;
                r.last = (k == frame_len - 1);
                sentence_out_q.push_back(r);
            end
            replayed++;
        end
        last_err  = err;
        last_kind = kind;
        frame_len = 0;
        in_frame  = 1'b0;
        sum_xor   = '0;
        past_star = 1'b0;
        head_xor  = '0;
        too_long  = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Result channel: check each transaction against the oldest owed result
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_res got;
        t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.ch   = o_out_byte;
            got.idx  = o_byte_index;
            got.ok   = o_sentence_valid;
            got.kind = nsfc_pkg::t_stype'(o_sentence_type);
            got.err  = nsfc_pkg::t_err'(o_error_kind);
            got.last = o_last;
            results_seen++;
            if (sentence_out_q.size() == 0) begin
                note_fault($sformatf("result with nothing owed: %s", res_text(got)));
            end else begin
                want = sentence_out_q.pop_front();
                if (got !== want)
                    note_fault($sformatf("result %0d\n  want %s\n  got  %s",
                                         results_seen, res_text(want), res_text(got)));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall runs, one long hold-off on request, none when no_idle
    // ------------------------------------------------------------------
    initial begin : receiver
        int run;
        int r;
        run = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_pending) begin
                // hold off long enough for the sender to back up behind a CR
                hold_off_pending = 1'b0;
                hold_offs_done++;
                i_out_stall <= 1'b1;
                run = HOLD_CYCLES;
            end else if (run > 0) begin
                run--;
            end else if (no_idle) begin
                i_out_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    i_out_stall <= 1'b0;
                    run = $urandom_range(0, 6);
                end else if (r < 90) begin
                    i_out_stall <= 1'b1;
                    run = $urandom_range(0, 2);
                end else if (r < 98) begin
                    i_out_stall <= 1'b1;
                    run = $urandom_range(3, 12);
                end else begin
                    i_out_stall <= 1'b1;
                    run = $urandom_range(30, 80);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one byte after an optional gap and hold it until the block takes it.
    // Entered and left at a rising edge.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_offered++;
        frame_char(b);
    endtask

    // Drop valid, wait until every owed result has come out, then idle a little longer.
    task automatic drain_wait(input int extra);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sentence_out_q.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [nsfc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == nsfc_pkg::CFG_GGA_SUM) gga_key = val;
        else if (idx == nsfc_pkg::CFG_RMC_SUM) rmc_key = val;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return CH_0 + 8'(n);
        return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(n - 4'd10);
    endfunction

    function automatic logic [7:0] body_char();
        logic [7:0] c;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 5) c = 8'($urandom_range(0, 255));
        else if (r < 8) c = nsfc_pkg::CH_DOLLAR;
        else c = 8'($urandom_range(32, 126));
        // keep the CR and the star for the tail
        if (c == nsfc_pkg::CH_CR || c == nsfc_pkg::CH_STAR) c = CH_COMMA;
        return c;
    endfunction

    // Build one random sentence into tx_burst: mostly well formed with random content,
    // the rest with a wrong sum, a bad digit, no star, a missing tail or an overlong body.
    task automatic build_sentence();
        logic [7:0] body [$];
        logic [7:0] x;
        logic [7:0] b;
        logic [7:0] hi;
        logic [7:0] lo;
        string      hdr;
        int         r;
        int         n;
        if ($urandom_range(0, 99) < 20)
            repeat ($urandom_range(1, 4)) tx_burst.push_back(8'($urandom_range(0, 255)));
        r = $urandom_range(0, 99);
        hdr = "";
        if (r < 30) begin
            hdr = "GPGGA";
        end else if (r < 50) begin
            hdr = "GPRMC";
        end else begin
            x = '0;
            repeat (4) begin
                b = 8'($urandom_range(CH_UA, "Z"));
                body.push_back(b);
                x ^= b;
            end
            // steer the fifth letter so the header hits one of the keys, unless r is 80 or more
            b = ($urandom_range(0, 1) ? gga_key : rmc_key) ^ x;
            if (r >= 80) b = 8'($urandom_range(CH_UA, "Z"));
            if (b == nsfc_pkg::CH_CR || b == nsfc_pkg::CH_DOLLAR || b == nsfc_pkg::CH_STAR)
                b = CH_UA;
            body.push_back(b);
        end
        for (int i = 0; i < hdr.len(); i++) body.push_back(hdr[i]);

        r = $urandom_range(0, 99);
        if (r < 90) n = $urandom_range(0, 15);
        else if (r < 97) n = $urandom_range(16, 50);
        else n = $urandom_range(52, 70);
        repeat (n) body.push_back(body_char());

        x = '0;
        foreach (body[i]) if (body[i] != nsfc_pkg::CH_DOLLAR) x ^= body[i];

        r = $urandom_range(0, 99);
        if (r < 83) begin
            if (r >= 75) x ^= 8'($urandom_range(1, 255));
            body.push_back(nsfc_pkg::CH_STAR);
            body.push_back(hex_char(x[7:4]));
            body.push_back(hex_char(x[3:0]));
        end else if (r < 90) begin
            hi = hex_char(x[7:4]);
            lo = hex_char(x[3:0]);
            do b = 8'($urandom_range(0, 255));
            while (hex_value(b) >= 0 || b == nsfc_pkg::CH_CR);
            if ($urandom_range(0, 1)) hi = b;
            else lo = b;
            body.push_back(nsfc_pkg::CH_STAR);
            body.push_back(hi);
            body.push_back(lo);
        end else if (r < 95) begin
            repeat (2) body.push_back(hex_char(4'($urandom_range(0, 15))));
        end else begin
            repeat ($urandom_range(0, 1)) body.push_back(hex_char(4'($urandom_range(0, 15))));
        end

        tx_burst.push_back(nsfc_pkg::CH_DOLLAR);
        foreach (body[i]) tx_burst.push_back(body[i]);
        tx_burst.push_back(nsfc_pkg::CH_CR);
    endtask

    // Directed table builders
    function automatic void put_char(input logic [7:0] c);
        t_row r;
        r    = '0;
        r.ch = c;
        dir_rows.push_back(r);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endfunction

    function automatic void put_end(input nsfc_pkg::t_err e, input nsfc_pkg::t_stype k);
        t_row r;
        r       = '0;
        r.ch    = nsfc_pkg::CH_CR;
        r.check = 1'b1;
        r.err   = e;
        r.kind  = k;
        dir_rows.push_back(r);
    endfunction

    function automatic void put_reg(input logic [nsfc_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [7:0] val);
        t_row r;
        r        = '0;
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.ch     = val;
        dir_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_row       row;
        int         phase_sent;
        logic [7:0] key;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_rx_byte  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= nsfc_pkg::CFG_GGA_SUM;
        i_cfg_data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, header registers at their reset values first.
        // hunting noise
        put_char(8'h00); put_char(8'hFF); put_char(nsfc_pkg::CH_STAR); put_char(nsfc_pkg::CH_CR);
        put_text("$");         put_end(nsfc_pkg::ERR_LENGTH, nsfc_pkg::TYPE_UNKNOWN);   // one byte
        put_text("$0");        put_end(nsfc_pkg::ERR_BAD_HEX, nsfc_pkg::TYPE_UNKNOWN);  // dollar
        put_text("$00");       put_end(nsfc_pkg::ERR_NONE, nsfc_pkg::TYPE_UNKNOWN);     // no star
        put_text("$GPGGA*56"); put_end(nsfc_pkg::ERR_NONE, nsfc_pkg::TYPE_GGA);
        put_text("$GPRMC*4b"); put_end(nsfc_pkg::ERR_NONE, nsfc_pkg::TYPE_RMC);
        put_text("$GPRMC*4G"); put_end(nsfc_pkg::ERR_BAD_HEX, nsfc_pkg::TYPE_UNKNOWN);
        put_text("$GPGGA*57"); put_end(nsfc_pkg::ERR_CHECKSUM, nsfc_pkg::TYPE_UNKNOWN);
        // second dollar skipped
        put_text("$A$A*00");   put_end(nsfc_pkg::ERR_NONE, nsfc_pkg::TYPE_UNKNOWN);
        put_char(nsfc_pkg::CH_DOLLAR); put_char(8'h00); put_char(8'hFF); put_text("*FF");
        put_end(nsfc_pkg::ERR_NONE, nsfc_pkg::TYPE_UNKNOWN);
        // exactly a full store: index runs to 63
        put_char(nsfc_pkg::CH_DOLLAR); repeat (60) put_char(CH_UA); put_text("*00");
        put_end(nsfc_pkg::ERR_NONE, nsfc_pkg::TYPE_UNKNOWN);
        // two bytes past full: store overflows
        put_char(nsfc_pkg::CH_DOLLAR); repeat (62) put_char(CH_UA); put_text("*00");
        put_end(nsfc_pkg::ERR_LENGTH, nsfc_pkg::TYPE_UNKNOWN);
        // both keys zero: GGA wins on a zero header
        put_reg(nsfc_pkg::CFG_GGA_SUM, 8'h00); put_reg(nsfc_pkg::CFG_RMC_SUM, 8'h00);
        put_text("$00"); put_end(nsfc_pkg::ERR_NONE, nsfc_pkg::TYPE_GGA);
        // spare indexes must not disturb either key
        put_reg(CFG_SPARE_2, 8'hFF); put_reg(CFG_SPARE_3, 8'h00);
        put_reg(nsfc_pkg::CFG_GGA_SUM, 8'hFF);
        put_text("$00"); put_end(nsfc_pkg::ERR_NONE, nsfc_pkg::TYPE_RMC);
        put_reg(nsfc_pkg::CFG_RMC_SUM, 8'hFF);
        put_char(nsfc_pkg::CH_DOLLAR); put_char(8'h00); put_char(8'hFF); put_text("*FF");
        put_end(nsfc_pkg::ERR_NONE, nsfc_pkg::TYPE_GGA);

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.is_reg) begin
                drain_wait(SETTLE_TICKS);
                write_reg(row.idx, row.ch);
            end else begin
                send_byte(row.ch);
                if (row.check && (last_err != row.err || last_kind != row.kind))
                    note_fault($sformatf("directed row %0d: err %0d type %0d, want %0d %0d",
                                         k, int'(last_err), int'(last_kind),
                                         int'(row.err), int'(row.kind)));
            end
        end

        // Random part: one register setting per phase, written while the block is idle.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_wait(SETTLE_TICKS);
            case (ph)
                0: begin
                    write_reg(nsfc_pkg::CFG_GGA_SUM, nsfc_pkg::GGA_SUM_RST);
                    write_reg(nsfc_pkg::CFG_RMC_SUM, nsfc_pkg::RMC_SUM_RST);
                end
                1: begin
                    write_reg(nsfc_pkg::CFG_GGA_SUM, nsfc_pkg::RMC_SUM_RST);
                    write_reg(nsfc_pkg::CFG_RMC_SUM, nsfc_pkg::GGA_SUM_RST);
                end
                2: begin
                    write_reg(nsfc_pkg::CFG_GGA_SUM, 8'($urandom_range(0, 255)));
                    write_reg(nsfc_pkg::CFG_RMC_SUM, 8'($urandom_range(0, 255)));
                end
                3: begin
                    key = 8'($urandom_range(0, 255));
                    write_reg(nsfc_pkg::CFG_GGA_SUM, key);
                    write_reg(nsfc_pkg::CFG_RMC_SUM, key);
                end
                4: begin
                    write_reg(nsfc_pkg::CFG_GGA_SUM, 8'hFF);
                    write_reg(nsfc_pkg::CFG_RMC_SUM, 8'h00);
                end
                default: begin
                    write_reg(nsfc_pkg::CFG_GGA_SUM, 8'h00);
                    write_reg(nsfc_pkg::CFG_RMC_SUM, 8'hFF);
                end
            endcase
            // phase 1 backs the sender up behind a long hold-off; phase 3 runs flat out
            if (ph == 1) hold_off_pending = 1'b1;
            no_idle = (ph == 3);
            phase_sent = 0;
            while (phase_sent < PHASE_BYTES) begin
                build_sentence();
                while (tx_burst.size() != 0) begin
                    send_byte(tx_burst.pop_front());
                    phase_sent++;
                end
            end
        end
        no_idle = 1'b0;
        drain_wait(SETTLE_TICKS);

        if (sentence_out_q.size() != 0)
            note_fault($sformatf("%0d results never came out", sentence_out_q.size()));
        $display("summary: %0d bytes sent, %0d results checked, %0d sentences replayed",
                 bytes_offered, results_seen, replayed);
        $display("summary: errors checksum %0d, hex %0d, length %0d; %0d long hold-offs",
                 err_tally[int'(nsfc_pkg::ERR_CHECKSUM)], err_tally[int'(nsfc_pkg::ERR_BAD_HEX)],
                 err_tally[int'(nsfc_pkg::ERR_LENGTH)], hold_offs_done);
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
